FILE: src/occ_rdq_pkg.sv
// shared constants and types for the occlusion rectangle depth query block
`default_nettype none

package occ_rdq_pkg;

  // default grid edge length in cells
  localparam int GRID_DIM_DEF = 64;

  // payload widths
  localparam int MODE_W   = 1;
  localparam int COORD_W  = 6;
  localparam int EDGE_W   = 18;
  localparam int DEPTH_W  = 32;

  // q1.16 edge conversion
  localparam int FRAC_W   = 16;
  localparam int SCALE_W  = 10;  // signed width that holds any grid dimension
  localparam int PROD_W   = 29;  // edge times dimension plus one half, with margin
  localparam int CELL_W   = PROD_W - FRAC_W;
  localparam int EXT_W    = 9;   // unsigned width that holds any grid dimension

  localparam logic [PROD_W-1:0] HALF_ONE = PROD_W'(32768);

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // order in which the shared edge unit converts the rectangle edges
  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_sel_t;

endpackage

`default_nettype wire

FILE: src/occlusion_rect_depth_query.sv
// occlusion rectangle depth query: depth grid memory, edge unit and scan sequencer
//
// keeps a GRID_DIM x GRID_DIM grid of signed 32-bit depths in a single-port
// memory addressed {row, col}. a write beat (mode 0) stores one cell in the
// cycle it is taken and produces no result; writes outside the grid are
// dropped. a query beat (mode 1) runs in two phases: first, in turn, one
// shared multiply/round/clamp unit turns left, right, top and bottom into
// cell indices (floor(v*GRID_DIM + 0.5), low corner clamped to the grid, high
// corner clamped to [low, GRID_DIM-1]); then a scan that reads one cell per
// cycle row by row through the memory's registered read port and compares it
// with query_depth + 1 (33 bits, no wrap); it stops at the first cell that is
// farther, so a hit ends the scan early; the memory read port sets the
// one-cell-per-cycle scan. one query is in flight at a time. a finished
// result sits in the output register; write beats are still taken while it
// waits, a new query is taken once that result has gone or leaves in the
// same cycle. reading a cell that was never written returns whatever the
// memory holds.
`default_nettype none

module occlusion_rect_depth_query #(
  parameter int GRID_DIM = occ_rdq_pkg::GRID_DIM_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [occ_rdq_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [occ_rdq_pkg::COORD_W-1:0]     in_write_col,
  input  wire logic [occ_rdq_pkg::COORD_W-1:0]     in_write_row,
  input  wire logic signed [occ_rdq_pkg::DEPTH_W-1:0] in_write_depth,
  input  wire logic signed [occ_rdq_pkg::EDGE_W-1:0]  in_rect_left,
  input  wire logic signed [occ_rdq_pkg::EDGE_W-1:0]  in_rect_top,
  input  wire logic signed [occ_rdq_pkg::EDGE_W-1:0]  in_rect_right,
  input  wire logic signed [occ_rdq_pkg::EDGE_W-1:0]  in_rect_bottom,
  input  wire logic signed [occ_rdq_pkg::DEPTH_W-1:0] in_query_depth,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_visible
);

  localparam int IDX_W     = $clog2(GRID_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int EDGE_W    = occ_rdq_pkg::EDGE_W;
  localparam int DEPTH_W   = occ_rdq_pkg::DEPTH_W;
  localparam int PROD_W    = occ_rdq_pkg::PROD_W;
  localparam int CELL_W    = occ_rdq_pkg::CELL_W;
  localparam int EXT_W     = occ_rdq_pkg::EXT_W;
  localparam int SCALE_W   = occ_rdq_pkg::SCALE_W;
  localparam int Z_W       = DEPTH_W + 1;

  localparam logic [EXT_W-1:0]          GRID_EXT  = EXT_W'(GRID_DIM);
  localparam logic signed [SCALE_W-1:0] GRID_S    = SCALE_W'(GRID_DIM);
  localparam logic signed [CELL_W-1:0]  CELL_MAX  = CELL_W'(GRID_DIM - 1);

  // one-hot sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EDGE = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // latched query
  logic signed [EDGE_W-1:0] left_r, right_r, top_r, bottom_r;
  logic signed [Z_W-1:0]    z_r;

  // cell bounds from the edge unit
  logic [IDX_W-1:0] x0_r, x1_r, y0_r, y1_r;
  occ_rdq_pkg::edge_sel_t edge_r, edge_nxt;

  // scan position and read pipeline
  logic [IDX_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               scan_done_r, scan_done_nxt;
  logic [DEPTH_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;

  logic out_valid_r, out_valid_nxt;
  logic out_visible_r, out_visible_nxt;

  logic [DEPTH_W-1:0] mem [MEM_DEPTH];

  // beat decode
  logic accept, accept_write, accept_query;
  logic [EXT_W-1:0] wcol_ext, wrow_ext;
  logic wr_in_grid;
  logic [ADDR_W-1:0] wr_addr;

  assign in_ready     = (state_r == S_IDLE)
                        && (!out_valid_r || out_ready || (in_mode == occ_rdq_pkg::MODE_WRITE));
  assign accept       = in_valid && in_ready;
  assign accept_write = accept && (in_mode == occ_rdq_pkg::MODE_WRITE);
  assign accept_query = accept && (in_mode == occ_rdq_pkg::MODE_QUERY);

  assign wcol_ext   = EXT_W'(in_write_col);
  assign wrow_ext   = EXT_W'(in_write_row);
  assign wr_in_grid = (wcol_ext < GRID_EXT) && (wrow_ext < GRID_EXT);
  assign wr_addr    = {wrow_ext[IDX_W-1:0], wcol_ext[IDX_W-1:0]};

  // shared edge unit: one multiply by the grid size, round, then clamp
  logic signed [EDGE_W-1:0] edge_in;
  logic signed [PROD_W-1:0] edge_prod;
  logic signed [CELL_W-1:0] edge_cell;
  logic [IDX_W-1:0]         edge_lo;
  logic signed [CELL_W-1:0] edge_lo_s;
  logic [IDX_W-1:0]         edge_idx;

  always_comb begin
    case (edge_r)
      occ_rdq_pkg::EDGE_LEFT:   edge_in = left_r;
      occ_rdq_pkg::EDGE_RIGHT:  edge_in = right_r;
      occ_rdq_pkg::EDGE_TOP:    edge_in = top_r;
      default:                  edge_in = bottom_r;
    endcase
    // high edges are clamped up to the low edge already found
    case (edge_r)
      occ_rdq_pkg::EDGE_RIGHT:  edge_lo = x0_r;
      occ_rdq_pkg::EDGE_BOTTOM: edge_lo = y0_r;
      default:                  edge_lo = '0;
    endcase
  end

  assign edge_prod = $signed({{(PROD_W-EDGE_W){edge_in[EDGE_W-1]}}, edge_in})
                     * $signed({{(PROD_W-SCALE_W){GRID_S[SCALE_W-1]}}, GRID_S})
                     + $signed(occ_rdq_pkg::HALF_ONE);
  // arithmetic shift gives the floor
  assign edge_cell = edge_prod[PROD_W-1:occ_rdq_pkg::FRAC_W];
  assign edge_lo_s = $signed(CELL_W'(edge_lo));

  always_comb begin
    if (edge_cell < edge_lo_s) begin
      edge_idx = edge_lo;
    end else if (edge_cell > CELL_MAX) begin
      edge_idx = CELL_MAX[IDX_W-1:0];
    end else begin
      edge_idx = edge_cell[IDX_W-1:0];
    end
  end

  // compare of the cell read last cycle
  logic hit;
  assign hit = rd_vld_r
               && (z_r < $signed({rd_data_r[DEPTH_W-1], rd_data_r}));

  // scan stepping, row major
  logic last_col, last_cell;
  assign last_col  = (cx_r == x1_r);
  assign last_cell = last_col && (cy_r == y1_r);
  assign rd_addr   = {cy_r, cx_r};

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    edge_nxt        = edge_r;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    rd_vld_nxt      = 1'b0;
    scan_done_nxt   = scan_done_r;
    rd_en           = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_visible_nxt = out_visible_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept_query) begin
          state_nxt = S_EDGE;
          edge_nxt  = occ_rdq_pkg::EDGE_LEFT;
        end
      end
      S_EDGE: begin
        edge_nxt = occ_rdq_pkg::edge_sel_t'(edge_r + 2'd1);
        if (edge_r == occ_rdq_pkg::EDGE_BOTTOM) begin
          state_nxt     = S_SCAN;
          cx_nxt        = x0_r;
          cy_nxt        = y0_r;
          scan_done_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // early exit on the first farther cell
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b1;
        end else if (scan_done_r) begin
          // last cell compared, nothing farther
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b0;
        end else begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          if (last_cell) begin
            scan_done_nxt = 1'b1;
          end else if (last_col) begin
            cx_nxt = x0_r;
            cy_nxt = cy_r + IDX_W'(1);
          end else begin
            cx_nxt = cx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      edge_r        <= occ_rdq_pkg::EDGE_LEFT;
      rd_vld_r      <= 1'b0;
      scan_done_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      edge_r        <= edge_nxt;
      rd_vld_r      <= rd_vld_nxt;
      scan_done_r   <= scan_done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
    cx_r          <= cx_nxt;
    cy_r          <= cy_nxt;
    if (accept_query) begin
      left_r   <= in_rect_left;
      right_r  <= in_rect_right;
      top_r    <= in_rect_top;
      bottom_r <= in_rect_bottom;
      z_r      <= $signed({in_query_depth[DEPTH_W-1], in_query_depth}) + Z_W'(1);
    end
    if (state_r == S_EDGE) begin
      case (edge_r)
        occ_rdq_pkg::EDGE_LEFT:  x0_r <= edge_idx;
        occ_rdq_pkg::EDGE_RIGHT: x1_r <= edge_idx;
        occ_rdq_pkg::EDGE_TOP:   y0_r <= edge_idx;
        default:                 y1_r <= edge_idx;
      endcase
    end
  end

  // depth grid: write on a write beat, registered read during the scan
  always_ff @(posedge clk) begin
    if (accept_write && wr_in_grid) begin
      mem[wr_addr] <= in_write_depth;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

`default_nettype wire

FILE: src/occ_rdq_checker.sv
// port-level checks for the occlusion rectangle depth query block
`default_nettype none

module occ_rdq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_mode,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_visible
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("result beat dropped or changed while stalled");

  // a write beat never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == occ_rdq_pkg::MODE_WRITE) && !out_valid
    |=> !out_valid)
    else $error("result appeared after a write beat");

  // a query occupies the block
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == occ_rdq_pkg::MODE_QUERY) |=> !in_ready)
    else $error("input taken while a query is running");

  // a new result only comes out of a running query
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a running query");

endmodule

bind occlusion_rect_depth_query occ_rdq_checker u_occ_rdq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_mode     (in_mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_visible (out_visible)
);

`default_nettype wire
